>>> rtl/lpcs_pkg.sv
`default_nettype none
package lpcs_pkg;

    localparam int FRAME_BYTES   = 15;
    localparam int FILTER_STAGES = 6;
    localparam int CNT_W         = 4;
    localparam logic [14:0] NOISE_SEED   = 15'h7fff;
    localparam logic [12:0] IDLE_DEFAULT = 13'd4480;
    localparam logic [13:0] IDLE_MAX     = 14'd16383;
    localparam logic [0:0]  MODE_PUSH    = 1'b0;
    localparam logic [0:0]  MODE_TICK    = 1'b1;

    typedef struct packed {
        logic signed [9:0] fwd;
        logic signed [9:0] bck;
    } lpcs_coef_t;

    typedef struct packed {
        logic              start;
        logic              load;
    } lpcs_ctrl_t;

    function automatic logic [8:0] lpcs_mag(input logic [6:0] idx);
        logic [8:0] m;
        begin
            if (idx < 7'd38)
                m = 9'(idx * 8 + ((idx == 7'd0) ? 0 : 1));
            else if (idx < 7'd70)
                m = 9'(301 + (idx - 7'd38) * 4);
            else if (idx < 7'd98)
                m = 9'(427 + (idx - 7'd70) * 2);
            else
                m = 9'(482 + (idx - 7'd98));
            lpcs_mag = m;
        end
    endfunction

    function automatic logic signed [9:0] lpcs_coef(input logic [7:0] b);
        logic [9:0] m;
        begin
            m = {1'b0, lpcs_mag(b[6:0])};
            lpcs_coef = b[7] ? $signed(m) : -$signed(m);
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/lpcs_cell.sv
`default_nettype none
module lpcs_cell
    import lpcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lpcs_ctrl_t         ctrl,
    input  wire lpcs_coef_t         coef,
    input  wire logic               in_valid,
    input  wire logic signed [15:0] in_z,
    output logic                    out_valid,
    output logic signed [15:0]      out_z
);

    logic signed [15:0] d1_reg, d2_reg;
    logic signed [15:0] d1_next, d2_next;
    logic signed [25:0] pf_reg, pb_reg;
    logic signed [15:0] z_reg;
    logic               v_reg;
    logic signed [15:0] sum;

    assign sum = 16'(in_z + 16'(pf_reg >>> 8) + 16'(pb_reg >>> 9));

    always_comb
    begin
        d1_next = d1_reg;
        d2_next = d2_reg;
        if (ctrl.load)
        begin
            d1_next = '0;
            d2_next = '0;
        end
        else if (in_valid)
        begin
            d1_next = sum;
            d2_next = d1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
            v_reg  <= 1'b0;
        end
        else
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            v_reg  <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            pf_reg <= d1_reg * coef.fwd;
            pb_reg <= d2_reg * coef.bck;
        end
        if (in_valid)
            z_reg <= sum;
    end

    assign out_valid = v_reg;
    assign out_z     = z_reg;

endmodule
`default_nettype wire

>>> rtl/lpcs_ctrl.sv
`default_nettype none
module lpcs_ctrl
    import lpcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tick,
    input  wire logic               push,
    input  wire logic [7:0]         data_byte,
    input  wire logic               mute,
    output lpcs_ctrl_t              ctrl,
    output lpcs_coef_t              coefs [FILTER_STAGES],
    output logic signed [15:0]      excite,
    output logic                    full,
    output logic                    full_next
);

    logic [7:0]       buf_reg [FRAME_BYTES];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    lpcs_coef_t       coef_reg [FILTER_STAGES];
    logic [11:0]      amp_reg;
    logic [14:0]      lfsr_reg, lfsr_next;
    logic [7:0]       pp_reg, pc_reg, rc_reg;
    logic [5:0]       rt_reg;
    logic             voiced_reg;
    logic             done, load;
    logic [7:0]       pc_cur, rc_cur;
    logic [5:0]       rt_cur;
    logic             voiced_cur;
    logic [11:0]      amp_cur;
    logic [7:0]       pp_cur;

    localparam int BACK_POS [FILTER_STAGES] = '{0, 3, 6, 9, 11, 13};

    assign full = (cnt_reg == CNT_W'(FRAME_BYTES));
    assign full_next = (cnt_next == CNT_W'(FRAME_BYTES));
    assign done = (rc_reg >= {2'b00, rt_reg});
    assign load = tick && !mute && done && full;
    assign ctrl.load  = load;
    assign ctrl.start = tick && !mute;

    always_comb
    begin
        pc_cur     = pc_reg;
        rc_cur     = rc_reg;
        rt_cur     = rt_reg;
        voiced_cur = voiced_reg;
        amp_cur    = amp_reg;
        pp_cur     = pp_reg;
        if (done)
        begin
            pc_cur = '0;
            rc_cur = '0;
            rt_cur = 6'd1;
            if (full)
            begin
                rt_cur     = buf_reg[8][5:0];
                voiced_cur = buf_reg[8][6];
                amp_cur    = 12'({7'd0, buf_reg[2][4:0]} << buf_reg[2][7:5]);
                pp_cur     = buf_reg[5];
            end
        end
        lfsr_next = {lfsr_reg[0] ^ lfsr_reg[1], lfsr_reg[14:1]};
        if (voiced_cur)
            excite = (pc_cur == 8'd0) ? $signed({4'd0, amp_cur}) : 16'sd0;
        else
            excite = lfsr_next[0] ? $signed({4'd0, amp_cur})
                                  : -$signed({4'd0, amp_cur});
        cnt_next = cnt_reg;
        if (push && !full)
            cnt_next = cnt_reg + 1'b1;
        else if (load)
            cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            amp_reg    <= '0;
            lfsr_reg   <= NOISE_SEED;
            pp_reg     <= '0;
            pc_reg     <= '0;
            rc_reg     <= '0;
            rt_reg     <= '0;
            voiced_reg <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++)
                buf_reg[i] <= '0;
            for (int s = 0; s < FILTER_STAGES; s++)
                coef_reg[s] <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push && !full)
                buf_reg[cnt_reg] <= data_byte;
            if (tick && !mute)
            begin
                lfsr_reg   <= lfsr_next;
                amp_reg    <= amp_cur;
                pp_reg     <= pp_cur;
                rt_reg     <= rt_cur;
                voiced_reg <= voiced_cur;
                if (pc_cur == pp_cur)
                begin
                    pc_reg <= '0;
                    rc_reg <= rc_cur + 1'b1;
                end
                else
                begin
                    pc_reg <= pc_cur + 1'b1;
                    rc_reg <= rc_cur;
                end
            end
            if (load)
                for (int s = 0; s < FILTER_STAGES; s++)
                begin
                    coef_reg[s].bck <= lpcs_coef(buf_reg[BACK_POS[s]]);
                    coef_reg[s].fwd <= lpcs_coef(buf_reg[BACK_POS[s] + 1]);
                end
        end
    end

    assign coefs = coef_reg;

endmodule
`default_nettype wire

>>> rtl/lpc_lattice_speech_synth_top.sv
// A push is answered in the cycle after it is taken; a tick is answered after the tick
// pipe register. One request at a time: no new request is taken until the response is
// accepted, and the excitation walks through the six-cell chain one cell per cycle.
// Reset clears the frame buffer, coefficients, delays and counters at once and
// loads the noise register with all ones; idle_limit returns to 4480.
`default_nettype none
module lpc_lattice_speech_synth_top
    import lpcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // sample[6:0], zero
    output logic [1:0]       m_tuser    // sample_valid, fifo_ready
);

    localparam int LAT = FILTER_STAGES + 2;

    logic [12:0]        limit_reg;
    logic [13:0]        idle_reg;
    logic [13:0]        idle_inc;
    logic               busy_reg;
    logic               acc, push, tick, mute;
    lpcs_ctrl_t         ctrl;
    lpcs_coef_t         coefs [FILTER_STAGES];
    logic signed [15:0] excite;
    logic               full;
    logic               full_next;
    logic               chain_v [FILTER_STAGES+1];
    logic signed [15:0] chain_z [FILTER_STAGES+1];
    logic               start_reg;
    logic               start2_reg;
    logic signed [15:0] ex_reg;
    logic               mute_reg;
    logic [LAT-1:0]     tick_pipe_reg;
    logic signed [9:0]  dac;
    logic [6:0]         clamp;

    assign pready = 1'b1;
    assign prdata = {19'd0, limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= IDLE_DEFAULT;
        else if (psel && penable && pwrite && paddr == 2'd0)
            limit_reg <= pwdata[12:0];
    end

    assign s_tready = !busy_reg;
    assign acc  = s_tvalid && s_tready;
    assign push = acc && s_tuser == MODE_PUSH;
    assign tick = acc && s_tuser == MODE_TICK;
    assign idle_inc = (idle_reg < IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;
    assign mute = {1'b0, limit_reg} < idle_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_reg <= '0;
        else if (push)
            idle_reg <= '0;
        else if (tick)
            idle_reg <= idle_inc;
    end

    lpcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .push      (push),
        .data_byte (s_tdata),
        .mute      (mute),
        .ctrl      (ctrl),
        .coefs     (coefs),
        .excite    (excite),
        .full      (full),
        .full_next (full_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 1'b0;
            start2_reg <= 1'b0;
            mute_reg   <= 1'b0;
        end
        else
        begin
            start_reg  <= ctrl.start;
            start2_reg <= start_reg;
            if (tick)
                mute_reg <= mute;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
            ex_reg <= excite;
    end

    assign chain_v[0] = start2_reg;
    assign chain_z[0] = ex_reg;

    genvar g;
    generate
        for (g = 0; g < FILTER_STAGES; g++)
        begin : g_cell
            lpcs_ctrl_t cc;
            assign cc.load = ctrl.load;
            if (g == 0)
            begin : g_first
                assign cc.start = start_reg;
            end
            else
            begin : g_rest
                assign cc.start = chain_v[g-1];
            end
            lpcs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cc),
                .coef      (coefs[g]),
                .in_valid  (chain_v[g]),
                .in_z      (chain_z[g]),
                .out_valid (chain_v[g+1]),
                .out_z     (chain_z[g+1])
            );
        end
    endgenerate

    assign dac = 10'(chain_z[FILTER_STAGES] >>> 6);
    assign clamp = (dac < -10'sd64) ? 7'h40 : (dac > 10'sd63) ? 7'h3f : dac[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            m_tvalid      <= 1'b0;
            tick_pipe_reg <= '0;
            m_tdata       <= '0;
            m_tuser       <= '0;
        end
        else
        begin
            tick_pipe_reg <= {tick_pipe_reg[LAT-2:0], tick};
            if (m_tvalid && m_tready)
            begin
                m_tvalid <= 1'b0;
                busy_reg <= 1'b0;
            end
            if (acc)
                busy_reg <= 1'b1;
            if (push)
            begin
                m_tvalid <= 1'b1;
                m_tdata  <= '0;
                m_tuser  <= {!full_next, 1'b0};
            end
            if (tick_pipe_reg[LAT-1])
            begin
                m_tvalid <= 1'b1;
                m_tdata  <= {1'b0, mute_reg ? 7'd0 : clamp};
                m_tuser  <= {!full, 1'b1};
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/lpcs_checker.sv
`default_nettype none
module lpcs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser
);

    a_push_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("push response carries a sample");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request taken while response pending");

    a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> m_tvalid && !m_tuser[0])
        else $error("push not answered next cycle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("response dropped");

endmodule

bind lpc_lattice_speech_synth_top lpcs_checker u_lpcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
